[hw/rtl/swqfs_pkg.sv]
// shared types and constants for the fit-select swap queue
// no dependencies; used by every module of the block
package swqfs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 16;
  localparam int SIZE_W      = 32;
  localparam int STAT_W      = 2;
  localparam int IN_DATA_W   = 88;
  localparam int OUT_DATA_W  = 24;

  localparam logic ACT_APPEND   = 1'b0;
  localparam logic ACT_RETRIEVE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NONE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  localparam logic POLICY_FIRST = 1'b0;
  localparam logic POLICY_BEST  = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
    logic              blocked;
  } entry_t;

  // running best candidate handed from cell to cell
  typedef struct packed {
    logic              found;
    logic [SIZE_W-1:0] key;
    logic [ID_W-1:0]   id;
    logic [IDX_W-1:0]  idx;
  } cand_t;

  typedef struct packed {
    logic              append;
    logic [IDX_W-1:0]  wr_idx;
    logic              remove;
    logic [IDX_W-1:0]  rm_idx;
    logic              eval;
    logic              step;
    logic [CNT_W-1:0]  count;
    logic [SIZE_W-1:0] avail;
    logic              allow;
    logic              policy;
    entry_t            new_entry;
  } ctl_t;

endpackage

[hw/rtl/swq_cell.sv]
// one queue slot: holds an entry, judges its own fit and passes the best
// candidate so far to the next slot; depends on swqfs_pkg
module swq_cell import swqfs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  ctl_t             ctl,
  input  logic [IDX_W-1:0] my_idx,
  input  entry_t           next_entry,
  output entry_t           entry,
  input  cand_t            cand_in,
  output cand_t            cand_out
);

  logic              in_use;
  logic              q_ok;
  logic [SIZE_W-1:0] q_key;
  logic              take_self;

  assign in_use    = {1'b0, my_idx} < ctl.count;
  assign take_self = q_ok && (!cand_in.found || (q_key < cand_in.key));

  always_ff @(posedge clk) begin
    if (ctl.append && (ctl.wr_idx == my_idx)) begin
      entry <= ctl.new_entry;
    end else if (ctl.remove && (my_idx >= ctl.rm_idx)) begin
      entry <= next_entry;
    end
    if (ctl.eval) begin
      q_ok <= in_use && (entry.size <= ctl.avail) && (ctl.allow || !entry.blocked);
      // first fit ranks unblocked ahead of blocked, best fit ranks by waste
      if (ctl.policy == POLICY_BEST) begin
        q_key <= ctl.avail - entry.size;
      end else begin
        q_key <= {{(SIZE_W-1){1'b0}}, entry.blocked};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out.found <= 1'b0;
    end else if (ctl.eval) begin
      cand_out.found <= 1'b0;
    end else if (ctl.step) begin
      if (take_self) begin
        cand_out.found <= 1'b1;
      end else begin
        cand_out.found <= cand_in.found;
      end
    end
    if (ctl.step) begin
      if (take_self) begin
        cand_out.key <= q_key;
        cand_out.id  <= entry.id;
        cand_out.idx <= my_idx;
      end else begin
        cand_out.key <= cand_in.key;
        cand_out.id  <= cand_in.id;
        cand_out.idx <= cand_in.idx;
      end
    end
  end

endmodule

[hw/rtl/swq_ctrl.sv]
// sequencer: takes a word, drives append, scan and removal over the cell
// row, keeps the entry count and the output register; depends on swqfs_pkg
module swq_ctrl import swqfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  policy,
  input  cand_t                 final_cand,
  output ctl_t                  ctl
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EVAL  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_APPLY = 5'b01000,
    ST_RESP  = 5'b10000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  scan_cnt;
  logic              item_action;
  entry_t            item_entry;
  logic [SIZE_W-1:0] item_avail;
  logic              item_allow;
  logic [ID_W-1:0]   res_id;
  logic [STAT_W-1:0] res_status;
  logic              full;
  logic              out_free;

  assign s_tready = (state == ST_IDLE);
  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    ctl.append    = (state == ST_APPLY) && (item_action == ACT_APPEND) && !full;
    ctl.wr_idx    = count[IDX_W-1:0];
    ctl.remove    = (state == ST_APPLY) && (item_action == ACT_RETRIEVE) && final_cand.found;
    ctl.rm_idx    = final_cand.idx;
    ctl.eval      = (state == ST_EVAL);
    ctl.step      = (state == ST_SCAN);
    ctl.count     = count;
    ctl.avail     = item_avail;
    ctl.allow     = item_allow;
    ctl.policy    = policy;
    ctl.new_entry = item_entry;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tuser == ACT_APPEND) ? ST_APPLY : ST_EVAL;
        end
      end
      ST_EVAL: state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_cnt == IDX_W'(QUEUE_DEPTH - 1)) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: state_next = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.append) begin
        count <= count + CNT_W'(1);
      end else if (ctl.remove) begin
        count <= count - CNT_W'(1);
      end
      if ((state == ST_RESP) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_action        <= s_tuser;
      item_entry.id      <= s_tdata[15:0];
      item_entry.size    <= s_tdata[47:16];
      item_entry.blocked <= s_tdata[48];
      item_avail         <= s_tdata[80:49];
      item_allow         <= s_tdata[81];
    end
    if (state == ST_EVAL) begin
      scan_cnt <= '0;
    end else if (state == ST_SCAN) begin
      scan_cnt <= scan_cnt + IDX_W'(1);
    end
    if (state == ST_APPLY) begin
      if (item_action == ACT_APPEND) begin
        res_id     <= '0;
        res_status <= full ? STAT_FULL : STAT_DONE;
      end else if (final_cand.found) begin
        res_id     <= final_cand.id;
        res_status <= STAT_DONE;
      end else begin
        res_id     <= '0;
        res_status <= STAT_NONE;
      end
    end
    if ((state == ST_RESP) && out_free) begin
      m_tdata <= {{(OUT_DATA_W-ID_W-STAT_W){1'b0}}, res_status, res_id};
    end
  end

endmodule

[hw/rtl/swap_queue_fit_select.sv]
// Ordered swap queue with first-fit / best-fit retrieval. An append word goes
// from acceptance through the apply and response states to the result. A retrieve
// word first has every slot judged in parallel in the eval state, then the
// best candidate ripples through the row of slot cells one cell per cycle,
// then the apply state removes the chosen slot by shifting the later slots down.
// One word is in work at a time; the finished word waits in the output
// register, and the next word is accepted once the result has moved there.
// Top level: apb policy register, cell row and sequencer; depends on swqfs_pkg.
module swap_queue_fit_select import swqfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [15:0] proc_id, [47:16] proc_size, [48] proc_blocked,
  // [80:49] size_available, [81] allow_blocked, [87:82] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [0] action
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [15:0] chosen_id, [17:16] status, [23:18] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam logic [2:0] ADDR_POLICY = 3'd0;

  logic   policy;
  ctl_t   ctl;
  entry_t ents  [QUEUE_DEPTH];
  cand_t  cands [QUEUE_DEPTH+1];

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_POLICY) ? {31'b0, policy} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POLICY_FIRST;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_POLICY)) begin
      policy <= pwdata[0];
    end
  end

  assign cands[0] = '0;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t nxt;
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign nxt = ents[g];
    end else begin : g_mid
      assign nxt = ents[g+1];
    end
    swq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .my_idx     (IDX_W'(g)),
      .next_entry (nxt),
      .entry      (ents[g]),
      .cand_in    (cands[g]),
      .cand_out   (cands[g+1])
    );
  end

  swq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .policy     (policy),
    .final_cand (cands[QUEUE_DEPTH]),
    .ctl        (ctl)
  );

endmodule

[hw/rtl/swq_check.sv]
// port-level checks for swap_queue_fit_select, attached by bind
// depends on swqfs_pkg
module swq_check import swqfs_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // only one word in work at a time
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word accepted while busy");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[17:16] == STAT_DONE) || (m_tdata[17:16] == STAT_NONE)
                 || (m_tdata[17:16] == STAT_FULL))
    else $error("bad status code");

  // an unsuccessful word never names an id
  a_noid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[17:16] != STAT_DONE) |-> m_tdata[15:0] == '0)
    else $error("id on failed word");

endmodule

bind swap_queue_fit_select swq_check u_check (.*);
